// File: src/snr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// snr_pkg
// Shared types and constants for the SPI NOR request splitter.
// ---------------------------------------------------------------------------
package snr_pkg;

  localparam int ADDR_W       = 24;
  localparam int LEN_W        = 14;
  localparam int PAGE_BYTES   = 256;
  localparam int SECTOR_BYTES = 4096;
  localparam int MAX_LENGTH   = 8192;
  localparam int PAGE_LOG2    = $clog2(PAGE_BYTES);
  localparam int SECT_LOG2    = $clog2(SECTOR_BYTES);
  localparam int SPAN_W       = ((SECT_LOG2 > LEN_W) ? SECT_LOG2 : LEN_W) + 1;

  typedef enum logic [1:0] {
    CMD_WRITE = 2'd0,
    CMD_READ  = 2'd1,
    CMD_ERASE = 2'd2,
    CMD_CHIP  = 2'd3
  } command_t;

  typedef enum logic [1:0] {
    KIND_PROGRAM = 2'd0,
    KIND_READ    = 2'd1,
    KIND_SECTOR  = 2'd2,
    KIND_CHIP    = 2'd3
  } kind_t;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_t;

  typedef struct packed {
    command_t           command;
    logic [ADDR_W-1:0]  start_address;
    logic [LEN_W-1:0]   byte_length;
  } request_t;

  typedef struct packed {
    kind_t              kind;
    logic [ADDR_W-1:0]  flash_address;
    logic [LEN_W-1:0]   data_count;
    logic               write_enable_first;
    logic               last;
  } transaction_t;

  typedef struct packed {
    command_t           cmd;
    logic [ADDR_W-1:0]  addr;
    logic [LEN_W-1:0]   rem;
  } job_t;

endpackage

`default_nettype wire

// File: src/snr_step_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// snr_step_unit
// Shared arithmetic that forms one transaction from the current job and
// advances the job's address and remaining count.
// ---------------------------------------------------------------------------
module snr_step_unit (
  input  snr_pkg::job_t         job,
  output snr_pkg::transaction_t xact,
  output snr_pkg::job_t         job_next
);
  import snr_pkg::*;

  logic [LEN_W-1:0]  room;
  logic [LEN_W-1:0]  chunk;
  logic [ADDR_W-1:0] inc;
  logic [LEN_W-1:0]  dec;

  assign room  = LEN_W'(PAGE_BYTES) - LEN_W'(job.addr[PAGE_LOG2-1:0]);
  assign chunk = (room > job.rem) ? job.rem : room;

  always_comb begin
    xact = '0;
    inc  = '0;
    dec  = '0;
    unique case (job.cmd)
      CMD_WRITE: begin
        xact.kind               = KIND_PROGRAM;
        xact.flash_address      = job.addr;
        xact.data_count         = chunk;
        xact.write_enable_first = 1'b1;
        xact.last               = (job.rem == chunk);
        inc                     = ADDR_W'(chunk);
        dec                     = chunk;
      end
      CMD_READ: begin
        xact.kind               = KIND_READ;
        xact.flash_address      = job.addr;
        xact.data_count         = job.rem;
        xact.write_enable_first = 1'b0;
        xact.last               = 1'b1;
      end
      CMD_ERASE: begin
        xact.kind               = KIND_SECTOR;
        xact.flash_address      = job.addr;
        xact.write_enable_first = 1'b1;
        xact.last               = (job.rem == '0);
        inc                     = ADDR_W'(SECTOR_BYTES);
        dec                     = LEN_W'(1);
      end
      CMD_CHIP: begin
        xact.kind               = KIND_CHIP;
        xact.write_enable_first = 1'b1;
        xact.last               = 1'b1;
      end
      default: begin
        xact = '0;
      end
    endcase
  end

  assign job_next.cmd  = job.cmd;
  assign job_next.addr = job.addr + inc;
  assign job_next.rem  = job.rem - dec;

endmodule

`default_nettype wire

// File: src/spi_nor_request_splitter_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// spi_nor_request_splitter_core
// Splits one flash request into its run of page-program, read, sector-erase
// or chip-erase transactions.
// ---------------------------------------------------------------------------
// A request holds the sequencer busy until its last transaction is emitted; the
// request is loaded into the job register, then each transaction into the output register.
// One transaction is formed per cycle by the shared step unit, which is the
// only arithmetic in the loop; a stalled output register holds the sequencer.
// A write of length zero leaves the sequencer idle and produces no output.
// Synchronous reset returns the sequencer to idle and clears the output valid.
module spi_nor_request_splitter_core (
  input  wire                   clk,
  input  wire                   rst,
  input  wire                   request_valid,
  output logic                  request_stall,
  input  snr_pkg::request_t     request,
  output logic                  transaction_valid,
  input  wire                   transaction_stall,
  output snr_pkg::transaction_t transaction
);
  import snr_pkg::*;

  state_t           state;
  state_t           state_next;
  job_t             job;
  job_t             job_next;
  job_t             job_load;
  job_t             job_step;
  transaction_t     step_xact;
  logic             accept;
  logic             emit;
  logic [LEN_W-1:0] len_sat;
  logic [SPAN_W-1:0] span_end;

  snr_step_unit u_step (
    .job      (job),
    .xact     (step_xact),
    .job_next (job_step)
  );

  assign accept  = request_valid && !request_stall;
  assign len_sat = (request.byte_length > LEN_W'(MAX_LENGTH)) ? LEN_W'(MAX_LENGTH)
                                                               : request.byte_length;
  assign span_end = SPAN_W'(request.start_address[SECT_LOG2-1:0]) + SPAN_W'(len_sat)
                    - SPAN_W'(1);

  always_comb begin
    job_load.cmd  = request.command;
    job_load.addr = request.start_address;
    job_load.rem  = len_sat;
    unique case (request.command)
      CMD_ERASE: begin
        job_load.addr = {request.start_address[ADDR_W-1:SECT_LOG2], {SECT_LOG2{1'b0}}};
        job_load.rem  = (len_sat == '0) ? '0 : LEN_W'(span_end >> SECT_LOG2);
      end
      CMD_CHIP: begin
        job_load.rem = '0;
      end
      default: begin
        job_load.rem = len_sat;
      end
    endcase
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept && !(request.command == CMD_WRITE && len_sat == '0)) begin
          state_next = ST_RUN;
        end
      end
      ST_RUN: begin
        if (emit && step_xact.last) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    request_stall = (state != ST_IDLE);
    emit          = (state == ST_RUN) && (!transaction_valid || !transaction_stall);
  end

  always_comb begin
    job_next = job;
    if (accept) begin
      job_next = job_load;
    end else if (emit) begin
      job_next = job_step;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= ST_IDLE;
      transaction_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (emit) begin
        transaction_valid <= 1'b1;
      end else if (!transaction_stall) begin
        transaction_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    job <= job_next;
    if (emit) begin
      transaction <= step_xact;
    end
  end

endmodule

`default_nettype wire
